// ===== sv/arph_pkg.sv =====
// Shared constants, codes and interface types of the address range profile histogram.
`default_nettype none
package arph_pkg;
  localparam int MAX_REGIONS = 64;
  localparam int ADDR_BITS = 32;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = IDX_W + 1;
  localparam int HIT_W = 32;
  localparam int REG_W = 6;
  localparam int ACT_W = 7;
  localparam int TID_W = 8;
  localparam int CMD_W = 2;
  localparam int KIND_W = 3;
  localparam int FLD_W = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATCHED = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_ACK     = 3'd0,
    KIND_MATCH   = 3'd1,
    KIND_LOST    = 3'd2,
    KIND_IGNORED = 3'd3,
    KIND_REPORT  = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_LOAD_RES,
    OP_IGNORE,
    OP_ACK,
    OP_TOTAL,
    OP_SRD,
    OP_SCMP,
    OP_LOST,
    OP_EMIT_RES,
    OP_RINIT,
    OP_RLDI,
    OP_RLDC,
    OP_RLDC2,
    OP_RRJ,
    OP_RCJ,
    OP_RCMP,
    OP_EMIT_CUR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic             match;
    logic             thread_hit;
    logic [CNT_W-1:0] n;
    logic             emit_ok;
  } dp_status_t;
endpackage
`default_nettype wire

// ===== sv/arph_ram.sv =====
// Generic single write port RAM with one registered read port.
`default_nettype none
module arph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/arph_datapath.sv =====
// Datapath of the profiler: region tables, counters, sort registers and output register.
`default_nettype none
module arph_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             accept_i,
  input  wire logic [arph_pkg::REG_W-1:0]       region_index_i,
  input  wire logic [arph_pkg::FLD_W-1:0]       region_start_i,
  input  wire logic [arph_pkg::FLD_W-1:0]       region_end_i,
  input  wire logic [arph_pkg::FLD_W-1:0]       sample_address_i,
  input  wire logic [arph_pkg::TID_W-1:0]       thread_id_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [arph_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [arph_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire arph_pkg::dp_cmd_t                cmd_i,
  output arph_pkg::dp_status_t                  status_o,
  input  wire logic                             out_stall_i,
  output logic                                  out_valid_o,
  output logic [arph_pkg::KIND_W-1:0]           kind_o,
  output logic [arph_pkg::REG_W-1:0]            region_o,
  output logic [arph_pkg::HIT_W-1:0]            hit_count_o,
  output logic [arph_pkg::HIT_W-1:0]            samples_total_o,
  output logic [arph_pkg::HIT_W-1:0]            samples_lost_o,
  output logic [arph_pkg::FLD_W-1:0]            lost_address_o,
  output logic                                  last_of_run_o
);
  localparam int IW = arph_pkg::IDX_W;
  localparam int AW = arph_pkg::ADDR_BITS;
  localparam int HW = arph_pkg::HIT_W;

  logic [arph_pkg::REG_W-1:0] index_q;
  logic [AW-1:0] rstart_q, rend_q, pc_q;
  logic [arph_pkg::TID_W-1:0] tid_q;
  logic [arph_pkg::ACT_W-1:0] active_q;
  logic [arph_pkg::TID_W-1:0] watched_q;
  logic [arph_pkg::MAX_REGIONS-1:0] vld_q;
  logic [HW-1:0] total_q, lost_q;
  logic [AW-1:0] last_lost_q;
  logic [arph_pkg::KIND_W-1:0] res_kind_q;
  logic [IW-1:0] res_region_q;
  logic [HW-1:0] res_hit_q;
  logic [IW-1:0] cur_idx_q, rj_q, cnt_raddr_q;
  logic [HW-1:0] cur_cnt_q;
  logic out_valid_q;

  logic [AW-1:0] start_rd, end_rd, start_lo;
  logic [HW-1:0] cnt_ram_rd, cnt_rd;
  logic [IW-1:0] rank_rd, cnt_raddr, rank_raddr, rank_waddr, rank_wdata, idx;
  logic rank_we, tab_we, idx_ok, match, swap, emit_ok, emit_res, emit_cur;
  logic [arph_pkg::CNT_W-1:0] n;

  assign idx = IW'(index_q);
  assign idx_ok = 32'(index_q) < arph_pkg::MAX_REGIONS;
  assign tab_we = (cmd_i.op == arph_pkg::OP_LOAD) && idx_ok;
  assign n = (32'(active_q) > arph_pkg::MAX_REGIONS) ? arph_pkg::CNT_W'(arph_pkg::MAX_REGIONS)
                                                     : arph_pkg::CNT_W'(active_q);
  assign cnt_rd = vld_q[cnt_raddr_q] ? cnt_ram_rd : '0;
  assign start_lo = start_rd & ~AW'(1);
  assign match = (pc_q >= start_lo) && (pc_q <= end_rd);
  assign swap = cur_cnt_q < cnt_rd;
  assign emit_ok = !out_valid_q || !out_stall_i;
  assign emit_res = (cmd_i.op == arph_pkg::OP_EMIT_RES) && emit_ok;
  assign emit_cur = (cmd_i.op == arph_pkg::OP_EMIT_CUR) && emit_ok;

  always_comb begin
    case (cmd_i.op)
      arph_pkg::OP_LOAD: cnt_raddr = idx;
      arph_pkg::OP_RLDC, arph_pkg::OP_RCJ: cnt_raddr = rank_rd;
      default: cnt_raddr = cmd_i.i;
    endcase
    rank_raddr = (cmd_i.op == arph_pkg::OP_RRJ) ? cmd_i.j : cmd_i.i;
    rank_we = (cmd_i.op == arph_pkg::OP_RINIT) || ((cmd_i.op == arph_pkg::OP_RCMP) && swap);
    rank_waddr = (cmd_i.op == arph_pkg::OP_RINIT) ? cmd_i.i : cmd_i.j;
    rank_wdata = (cmd_i.op == arph_pkg::OP_RINIT) ? cmd_i.i : cur_idx_q;
  end

  arph_ram #(.WIDTH(AW), .DEPTH(arph_pkg::MAX_REGIONS)) u_start (
    .clk_i, .we_i(tab_we), .waddr_i(idx), .wdata_i(rstart_q), .raddr_i(cmd_i.i),
    .rdata_o(start_rd)
  );
  arph_ram #(.WIDTH(AW), .DEPTH(arph_pkg::MAX_REGIONS)) u_end (
    .clk_i, .we_i(tab_we), .waddr_i(idx), .wdata_i(rend_q), .raddr_i(cmd_i.i),
    .rdata_o(end_rd)
  );
  arph_ram #(.WIDTH(HW), .DEPTH(arph_pkg::MAX_REGIONS)) u_count (
    .clk_i, .we_i((cmd_i.op == arph_pkg::OP_SCMP) && match), .waddr_i(cmd_i.i),
    .wdata_i(cnt_rd + HW'(1)), .raddr_i(cnt_raddr), .rdata_o(cnt_ram_rd)
  );
  arph_ram #(.WIDTH(IW), .DEPTH(arph_pkg::MAX_REGIONS)) u_rank (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wdata),
    .raddr_i(rank_raddr), .rdata_o(rank_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= arph_pkg::ACT_W'(arph_pkg::MAX_REGIONS);
      watched_q <= '0;
      vld_q <= '0;
      total_q <= '0;
      lost_q <= '0;
      last_lost_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          arph_pkg::CFG_ACTIVE: active_q <= arph_pkg::ACT_W'(cfg_data_i);
          arph_pkg::CFG_WATCHED: watched_q <= arph_pkg::TID_W'(cfg_data_i);
          default: ;
        endcase
      end
      case (cmd_i.op)
        arph_pkg::OP_CLEAR: begin
          vld_q <= '0;
          total_q <= '0;
          lost_q <= '0;
          last_lost_q <= '0;
        end
        arph_pkg::OP_TOTAL: total_q <= total_q + HW'(1);
        arph_pkg::OP_LOST: begin
          lost_q <= lost_q + HW'(1);
          last_lost_q <= pc_q;
        end
        arph_pkg::OP_SCMP: if (match) vld_q[cmd_i.i] <= 1'b1;
        default: ;
      endcase
      if (emit_res || emit_cur) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_raddr_q <= cnt_raddr;
    if (accept_i) begin
      index_q <= region_index_i;
      rstart_q <= AW'(region_start_i);
      rend_q <= AW'(region_end_i);
      pc_q <= AW'(sample_address_i);
      tid_q <= thread_id_i;
    end
    case (cmd_i.op)
      arph_pkg::OP_CLEAR, arph_pkg::OP_ACK, arph_pkg::OP_LOST, arph_pkg::OP_IGNORE: begin
        res_kind_q <= (cmd_i.op == arph_pkg::OP_LOST) ? arph_pkg::KIND_LOST :
                      (cmd_i.op == arph_pkg::OP_IGNORE) ? arph_pkg::KIND_IGNORED :
                      arph_pkg::KIND_ACK;
        res_region_q <= '0;
        res_hit_q <= '0;
      end
      arph_pkg::OP_LOAD_RES: begin
        res_kind_q <= arph_pkg::KIND_ACK;
        res_region_q <= idx_ok ? idx : '0;
        res_hit_q <= idx_ok ? cnt_rd : '0;
      end
      arph_pkg::OP_SCMP: begin
        res_kind_q <= arph_pkg::KIND_MATCH;
        res_region_q <= cmd_i.i;
        res_hit_q <= cnt_rd + HW'(1);
      end
      arph_pkg::OP_RLDC: cur_idx_q <= rank_rd;
      arph_pkg::OP_RLDC2: cur_cnt_q <= cnt_rd;
      arph_pkg::OP_RCJ: rj_q <= rank_rd;
      arph_pkg::OP_RCMP: begin
        if (swap) begin
          cur_idx_q <= rj_q;
          cur_cnt_q <= cnt_rd;
        end
      end
      default: ;
    endcase
    if (emit_res || emit_cur) begin
      kind_o <= emit_cur ? arph_pkg::KIND_REPORT : res_kind_q;
      region_o <= arph_pkg::REG_W'(emit_cur ? cur_idx_q : res_region_q);
      hit_count_o <= emit_cur ? cur_cnt_q : res_hit_q;
      samples_total_o <= total_q;
      samples_lost_o <= lost_q;
      lost_address_o <= arph_pkg::FLD_W'(last_lost_q);
      last_of_run_o <= emit_cur ? cmd_i.last : 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o.match = match;
  assign status_o.thread_hit = (tid_q == watched_q);
  assign status_o.n = n;
  assign status_o.emit_ok = emit_ok;
endmodule
`default_nettype wire

// ===== sv/arph_controller.sv =====
// Controller state machine that sequences commands, the region scan and the report sort.
`default_nettype none
module arph_controller (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        accept_i,
  input  wire logic [arph_pkg::CMD_W-1:0]  cmd_i,
  input  wire arph_pkg::dp_status_t        status_i,
  output arph_pkg::dp_cmd_t                cmd_o,
  output logic                             idle_o
);
  localparam int CW = arph_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_LOAD, ST_LOADRES, ST_SAMPLE, ST_SRD, ST_SCMP, ST_LOST,
    ST_EMIT, ST_REPORT, ST_RINIT, ST_RLDI, ST_RLDC, ST_RLDC2, ST_RJ, ST_RCJ_CMP
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, i_inc, j_inc;
  logic cmp_phase_q, cmp_phase_d;

  assign i_inc = i_q + CW'(1);
  assign j_inc = j_q + CW'(1);

  always_comb begin
    state_d = state_q;
    i_d = i_q;
    j_d = j_q;
    cmp_phase_d = cmp_phase_q;
    cmd_o.op = arph_pkg::OP_NONE;
    cmd_o.i = i_q[arph_pkg::IDX_W-1:0];
    cmd_o.j = j_q[arph_pkg::IDX_W-1:0];
    cmd_o.last = (i_inc == status_i.n);
    unique case (state_q)
      ST_IDLE: begin
        if (accept_i) begin
          unique case (arph_pkg::cmd_e'(cmd_i))
            arph_pkg::CMD_CLEAR: state_d = ST_CLEAR;
            arph_pkg::CMD_LOAD: state_d = ST_LOAD;
            arph_pkg::CMD_SAMPLE: state_d = ST_SAMPLE;
            arph_pkg::CMD_REPORT: state_d = ST_REPORT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        cmd_o.op = arph_pkg::OP_CLEAR;
        state_d = ST_EMIT;
      end
      ST_LOAD: begin
        cmd_o.op = arph_pkg::OP_LOAD;
        state_d = ST_LOADRES;
      end
      ST_LOADRES: begin
        cmd_o.op = arph_pkg::OP_LOAD_RES;
        state_d = ST_EMIT;
      end
      ST_SAMPLE: begin
        i_d = '0;
        if (status_i.thread_hit) begin
          cmd_o.op = arph_pkg::OP_TOTAL;
          state_d = (status_i.n == '0) ? ST_LOST : ST_SRD;
        end else begin
          cmd_o.op = arph_pkg::OP_IGNORE;
          state_d = ST_EMIT;
        end
      end
      ST_SRD: begin
        cmd_o.op = arph_pkg::OP_SRD;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (status_i.match) begin
          cmd_o.op = arph_pkg::OP_SCMP;
          state_d = ST_EMIT;
        end else begin
          i_d = i_inc;
          state_d = (i_inc == status_i.n) ? ST_LOST : ST_SRD;
        end
      end
      ST_LOST: begin
        cmd_o.op = arph_pkg::OP_LOST;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.op = arph_pkg::OP_EMIT_RES;
        if (status_i.emit_ok) state_d = ST_IDLE;
      end
      ST_REPORT: begin
        i_d = '0;
        if (status_i.n == '0) begin
          cmd_o.op = arph_pkg::OP_ACK;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_RINIT;
        end
      end
      ST_RINIT: begin
        cmd_o.op = arph_pkg::OP_RINIT;
        if (i_inc == status_i.n) begin
          i_d = '0;
          state_d = ST_RLDI;
        end else begin
          i_d = i_inc;
        end
      end
      ST_RLDI: begin
        cmd_o.op = arph_pkg::OP_RLDI;
        state_d = ST_RLDC;
      end
      ST_RLDC: begin
        cmd_o.op = arph_pkg::OP_RLDC;
        state_d = ST_RLDC2;
      end
      ST_RLDC2: begin
        cmd_o.op = arph_pkg::OP_RLDC2;
        j_d = i_inc;
        cmp_phase_d = 1'b0;
        state_d = (i_inc == status_i.n) ? ST_RCJ_CMP : ST_RJ;
      end
      ST_RJ: begin
        cmd_o.op = arph_pkg::OP_RRJ;
        cmp_phase_d = 1'b0;
        state_d = ST_RCJ_CMP;
      end
      ST_RCJ_CMP: begin
        if (j_q == status_i.n) begin
          cmd_o.op = arph_pkg::OP_EMIT_CUR;
          if (status_i.emit_ok) begin
            i_d = i_inc;
            state_d = (i_inc == status_i.n) ? ST_IDLE : ST_RLDI;
          end
        end else if (!cmp_phase_q) begin
          cmd_o.op = arph_pkg::OP_RCJ;
          cmp_phase_d = 1'b1;
        end else begin
          cmd_o.op = arph_pkg::OP_RCMP;
          j_d = j_inc;
          state_d = (j_inc == status_i.n) ? ST_RCJ_CMP : ST_RJ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q <= '0;
      j_q <= '0;
      cmp_phase_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q <= i_d;
      j_q <= j_d;
      cmp_phase_q <= cmp_phase_d;
    end
  end

  assign idle_o = (state_q == ST_IDLE);
endmodule
`default_nettype wire

// ===== sv/address_range_profile_histogram.sv =====
// Top level of the address range profile histogram sampling profiler.
// Clear and load each end in one acknowledge. A sample scans the regions in index order until
// one matches, else it counts as lost. A report seeds the rank table, then for each rank finds
// the largest remaining hit count and emits it, all on the single read port of the count memory.
// One command is worked on at a time; the output register frees the input side.
// Reset is asynchronous, active low: counts, totals and configuration reset at once.
`default_nettype none
module address_range_profile_histogram (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [arph_pkg::CMD_W-1:0]      cmd_i,
  input  wire logic [arph_pkg::REG_W-1:0]      region_index_i,
  input  wire logic [arph_pkg::FLD_W-1:0]      region_start_i,
  input  wire logic [arph_pkg::FLD_W-1:0]      region_end_i,
  input  wire logic [arph_pkg::FLD_W-1:0]      sample_address_i,
  input  wire logic [arph_pkg::TID_W-1:0]      thread_id_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [arph_pkg::KIND_W-1:0]          kind_o,
  output logic [arph_pkg::REG_W-1:0]           region_o,
  output logic [arph_pkg::HIT_W-1:0]           hit_count_o,
  output logic [arph_pkg::HIT_W-1:0]           samples_total_o,
  output logic [arph_pkg::HIT_W-1:0]           samples_lost_o,
  output logic [arph_pkg::FLD_W-1:0]           lost_address_o,
  output logic                                 last_of_run_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [arph_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [arph_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  arph_pkg::dp_cmd_t dp_cmd;
  arph_pkg::dp_status_t dp_status;
  logic idle, accept;

  assign accept = in_valid_i && idle;
  assign in_stall_o = !idle;
  assign cfg_ready_o = 1'b1;

  arph_controller u_ctrl (
    .clk_i, .rst_ni, .accept_i(accept), .cmd_i, .status_i(dp_status),
    .cmd_o(dp_cmd), .idle_o(idle)
  );

  arph_datapath u_dp (
    .clk_i, .rst_ni, .accept_i(accept), .region_index_i, .region_start_i, .region_end_i,
    .sample_address_i, .thread_id_i, .cfg_we_i(cfg_valid_i && cfg_ready_o), .cfg_index_i,
    .cfg_data_i, .cmd_i(dp_cmd), .status_o(dp_status), .out_stall_i, .out_valid_o,
    .kind_o, .region_o, .hit_count_o, .samples_total_o, .samples_lost_o, .lost_address_o,
    .last_of_run_o
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o) else $error("block not busy after an input transfer");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o <= arph_pkg::KIND_REPORT)) else $error("bad result kind");
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != arph_pkg::KIND_REPORT) |-> last_of_run_o)
    else $error("single result without last flag");
endmodule
`default_nettype wire
